// File: src/mine_neighbor_count_3x3_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mine neighbour counter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MINE_NEIGHBOR_COUNT_3X3_CORE_MACROS_SVH
`define MINE_NEIGHBOR_COUNT_3X3_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mnc_pkg.sv
// ----------------------------------------------------------------------------
// Mine neighbour counter package
// Field widths, register indexes, shared types and the neighbour popcount.
// ----------------------------------------------------------------------------
`default_nettype none

package mnc_pkg;

  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 5;
  localparam int COUNT_W    = 4;
  localparam int CFG_COLS_W = 6;
  localparam int CFG_ROWS_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0]  REG_COLS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_ROWS_IN_USE = 1'd1;
  localparam logic [CFG_COLS_W-1:0] COLS_RESET      = 6'd32;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET      = 13'd1;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    S_RUN,
    S_LAST,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic two_above;
    logic above;
    logic current;
  } row_bits_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic count_t popcount8(input logic [7:0] v);
    count_t acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + count_t'(v[i]);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: src/mine_neighbor_count_3x3_core.sv
// ----------------------------------------------------------------------------
// Mine neighbour counter, 3x3 window
// Counts the mines around every cell of a binary grid streamed in raster order.
// ----------------------------------------------------------------------------
// Input words carry one cell each, column 0 first, row by row. Each result
// word gives a cell position, its mine flag and the number of mines among its
// eight neighbours (zero for a mine); out_last_of_run marks an input's last result.
// A cell is reported once the row below it has reached the next column, so
// results trail the input by one row and one column. A result leaves from the
// output register, loaded on taking its completing word or in S_LAST or S_FLUSH.
// One input word is taken per cycle while in_stall is low. A word that ends a
// row, from the second row on, holds the input while state S_LAST emits the
// row's last result; the word that ends the frame also holds it while S_FLUSH
// emits the last row, as the single output register emits one result a cycle
// from the column mux over the cell row, unless the receiver stalls.
// A result waiting in the output register does not block the next input word
// unless the receiver stalls; while out_stall is high the result holds and
// in_stall rises. Reset clears the line buffers and the position and sets
// cols_in_use to 32 and rows_in_use to 1. The user must write registers only
// when the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module mine_neighbor_count_3x3_core #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cell_is_mine,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [mnc_pkg::OUT_ROW_W-1:0]       out_row,
  output logic [mnc_pkg::OUT_COL_W-1:0]       out_col,
  output logic                                out_is_mine,
  output mnc_pkg::count_t                     out_mine_count,
  output logic                                out_last_of_run,
  input  wire logic                           cfg_we,
  input  wire logic [mnc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mnc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [mnc_pkg::CFG_COLS_W-1:0] cfg_cols_r;
  logic [mnc_pkg::CFG_ROWS_W-1:0] cfg_rows_r;

  mnc_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [RW-1:0] hold_row_r, hold_row_nxt;
  logic          hold_eof_r, hold_eof_nxt;
  logic [CW-1:0] flush_k_r, flush_k_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [mnc_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [mnc_pkg::OUT_COL_W-1:0] out_col_r;
  logic                          out_mine_r;
  mnc_pkg::count_t               out_count_r;
  logic                          out_last_r;

  logic [CW-1:0] cols_m1;
  logic [RW-1:0] rows_m1;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic          eor, eof, emit_a, more;
  logic          slot_free, acc;

  logic                          load, use_flush;
  logic [CW-1:0]                 sel_col;
  logic [RW-1:0]                 o_row;
  logic [CW-1:0]                 o_col;
  logic                          o_last;
  logic                          sel_mine;
  mnc_pkg::count_t               sel_count;
  mnc_pkg::cell_ctl_t            ctl;

  mnc_pkg::row_bits_t bits_w       [MAX_COLS];
  mnc_pkg::count_t    norm_w       [MAX_COLS];
  mnc_pkg::count_t    flush_w      [MAX_COLS];
  logic               mine_norm_w  [MAX_COLS];
  logic               mine_flush_w [MAX_COLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= mnc_pkg::COLS_RESET;
      cfg_rows_r <= mnc_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mnc_pkg::REG_COLS_IN_USE: cfg_cols_r <= cfg_data[mnc_pkg::CFG_COLS_W-1:0];
        mnc_pkg::REG_ROWS_IN_USE: cfg_rows_r <= cfg_data[mnc_pkg::CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cols_m1 = (cfg_cols_r == '0) ? '0 :
                   (32'(cfg_cols_r) > MAX_COLS) ? CW'(MAX_COLS - 1) :
                   CW'(cfg_cols_r - 1'b1);
  assign rows_m1 = (cfg_rows_r == '0) ? '0 :
                   (32'(cfg_rows_r) > MAX_ROWS) ? RW'(MAX_ROWS - 1) :
                   RW'(cfg_rows_r - 1'b1);

  assign c_cur  = (col_cnt_r > cols_m1) ? cols_m1 : col_cnt_r;
  assign r_cur  = (row_cnt_r > rows_m1) ? rows_m1 : row_cnt_r;
  assign eor    = (c_cur == cols_m1);
  assign eof    = eor && (r_cur == rows_m1);
  assign emit_a = (r_cur != '0) && (c_cur != '0);
  assign more   = eor && ((r_cur != '0) || eof);

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != mnc_pkg::S_RUN) || !slot_free;
  assign acc       = in_valid && !in_stall;

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    mnc_pkg::row_bits_t left_w, right_w;
    if (i == 0) begin : g_left_edge
      assign left_w = '0;
    end else begin : g_left
      assign left_w = bits_w[i-1];
    end
    if (i == MAX_COLS - 1) begin : g_right_edge
      assign right_w = '0;
    end else begin : g_right
      assign right_w = bits_w[i+1];
    end

    mnc_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .set_i        (acc && in_cell_is_mine && (c_cur == CW'(i))),
      .act_i        (CW'(i) <= cols_m1),
      .left_i       (left_w),
      .right_i      (right_w),
      .bits_o       (bits_w[i]),
      .norm_o       (norm_w[i]),
      .mine_norm_o  (mine_norm_w[i]),
      .flush_o      (flush_w[i]),
      .mine_flush_o (mine_flush_w[i])
    );
  end

  always_comb begin
    case (st_r)
      mnc_pkg::S_RUN:   sel_col = c_cur - 1'b1;
      mnc_pkg::S_LAST:  sel_col = cols_m1;
      mnc_pkg::S_FLUSH: sel_col = flush_k_r;
      default:          sel_col = '0;
    endcase
  end

  assign use_flush = (st_r == mnc_pkg::S_FLUSH);
  assign sel_mine  = use_flush ? mine_flush_w[sel_col] : mine_norm_w[sel_col];
  assign sel_count = use_flush ? flush_w[sel_col] : norm_w[sel_col];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mnc_pkg::S_RUN: begin
        if (acc && more) begin
          st_nxt = (r_cur != '0) ? mnc_pkg::S_LAST : mnc_pkg::S_FLUSH;
        end
      end
      mnc_pkg::S_LAST: begin
        if (slot_free) begin
          st_nxt = hold_eof_r ? mnc_pkg::S_FLUSH : mnc_pkg::S_RUN;
        end
      end
      mnc_pkg::S_FLUSH: begin
        if (slot_free && (flush_k_r == cols_m1)) begin
          st_nxt = mnc_pkg::S_RUN;
        end
      end
      default: st_nxt = mnc_pkg::S_RUN;
    endcase
  end

  always_comb begin
    load         = 1'b0;
    o_row        = r_cur - 1'b1;
    o_col        = sel_col;
    o_last       = 1'b1;
    ctl          = '0;
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    hold_row_nxt = hold_row_r;
    hold_eof_nxt = hold_eof_r;
    flush_k_nxt  = flush_k_r;
    case (st_r)
      mnc_pkg::S_RUN: begin
        if (acc) begin
          load   = emit_a;
          o_last = !more;
          if (eor) begin
            if (more) begin
              hold_row_nxt = r_cur;
              hold_eof_nxt = eof;
              flush_k_nxt  = '0;
            end else begin
              ctl.shift   = 1'b1;
              row_cnt_nxt = r_cur + 1'b1;
              col_cnt_nxt = '0;
            end
          end else begin
            col_cnt_nxt = c_cur + 1'b1;
            row_cnt_nxt = r_cur;
          end
        end
      end
      mnc_pkg::S_LAST: begin
        o_row = hold_row_r - 1'b1;
        if (slot_free) begin
          load   = 1'b1;
          o_last = !hold_eof_r;
          if (hold_eof_r) begin
            flush_k_nxt = '0;
          end else begin
            ctl.shift   = 1'b1;
            row_cnt_nxt = hold_row_r + 1'b1;
            col_cnt_nxt = '0;
          end
        end
      end
      mnc_pkg::S_FLUSH: begin
        o_row = hold_row_r;
        if (slot_free) begin
          load   = 1'b1;
          o_last = (flush_k_r == cols_m1);
          if (flush_k_r == cols_m1) begin
            ctl.clear   = 1'b1;
            row_cnt_nxt = '0;
            col_cnt_nxt = '0;
          end else begin
            flush_k_nxt = flush_k_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mnc_pkg::S_RUN;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      flush_k_r   <= '0;
      hold_eof_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      flush_k_r   <= flush_k_nxt;
      hold_eof_r  <= hold_eof_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_row_r <= hold_row_nxt;
    if (load) begin
      out_row_r   <= mnc_pkg::OUT_ROW_W'(o_row);
      out_col_r   <= mnc_pkg::OUT_COL_W'(o_col);
      out_mine_r  <= sel_mine;
      out_count_r <= sel_count;
      out_last_r  <= o_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_is_mine     = out_mine_r;
  assign out_mine_count  = out_count_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// File: src/mnc_cell.sv
// ----------------------------------------------------------------------------
// Mine neighbour counter column cell
// Holds one column of the three line buffers, swaps bits with its two
// neighbours and forms the neighbour counts for its own column.
// ----------------------------------------------------------------------------
`default_nettype none

module mnc_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mnc_pkg::cell_ctl_t ctl,
  input  wire logic               set_i,
  input  wire logic               act_i,
  input  wire mnc_pkg::row_bits_t left_i,
  input  wire mnc_pkg::row_bits_t right_i,
  output mnc_pkg::row_bits_t      bits_o,
  output mnc_pkg::count_t         norm_o,
  output logic                    mine_norm_o,
  output mnc_pkg::count_t         flush_o,
  output logic                    mine_flush_o
);

  logic two_r, two_nxt;
  logic abv_r, abv_nxt;
  logic cur_r, cur_nxt;
  logic cur_eff;
  mnc_pkg::count_t norm_raw;
  mnc_pkg::count_t flush_raw;

  assign cur_eff = cur_r | set_i;

  always_comb begin
    two_nxt = two_r;
    abv_nxt = abv_r;
    cur_nxt = cur_eff;
    if (ctl.clear) begin
      two_nxt = 1'b0;
      abv_nxt = 1'b0;
      cur_nxt = 1'b0;
    end else if (ctl.shift) begin
      two_nxt = abv_r;
      abv_nxt = cur_eff;
      cur_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_r <= 1'b0;
      abv_r <= 1'b0;
      cur_r <= 1'b0;
    end else begin
      two_r <= two_nxt;
      abv_r <= abv_nxt;
      cur_r <= cur_nxt;
    end
  end

  assign bits_o = act_i ? mnc_pkg::row_bits_t'({two_r, abv_r, cur_eff})
                        : mnc_pkg::row_bits_t'('0);

  assign norm_raw = mnc_pkg::popcount8({left_i.two_above, two_r, right_i.two_above,
                                        left_i.above, right_i.above,
                                        left_i.current, cur_eff, right_i.current});
  assign flush_raw = mnc_pkg::popcount8({left_i.above, abv_r, right_i.above,
                                         left_i.current, right_i.current,
                                         3'b000});

  assign mine_norm_o  = abv_r;
  assign mine_flush_o = cur_eff;
  assign norm_o       = abv_r ? mnc_pkg::count_t'(0) : norm_raw;
  assign flush_o      = cur_eff ? mnc_pkg::count_t'(0) : flush_raw;

endmodule

`default_nettype wire

// File: src/mnc_chk.sv
// ----------------------------------------------------------------------------
// Mine neighbour counter port checker
// Watches the top-level ports for output holding and flow between channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mine_neighbor_count_3x3_core_macros.svh"

module mnc_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [mnc_pkg::OUT_ROW_W-1:0]  out_row,
  input wire logic [mnc_pkg::OUT_COL_W-1:0]  out_col,
  input wire logic                           out_is_mine,
  input wire mnc_pkg::count_t                out_mine_count,
  input wire logic                           out_last_of_run
);

  `MNC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({out_row, out_col, out_is_mine, out_mine_count, out_last_of_run}), "stalled result word changed")

  `MNC_ASSERT_SAME(a_in_needs_slot, in_valid && !in_stall, !out_valid || !out_stall, "input word taken while output slot blocked")

  `MNC_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_last_of_run, out_valid, "gap inside a run of result words")

endmodule

bind mine_neighbor_count_3x3_core mnc_chk u_mnc_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_row         (out_row),
  .out_col         (out_col),
  .out_is_mine     (out_is_mine),
  .out_mine_count  (out_mine_count),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire

// File: dv/tb_mine_neighbor_count_3x3_core.sv
// ----------------------------------------------------------------------------
// Testbench for the 3x3 mine neighbour counter
// Streams binary grids through the block under several grid sizes, including
// out-of-range and shrunk settings, and checks every result word against a
// local model of the line buffers. Sender and receiver idle at random, and the
// receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_mine_neighbor_count_3x3_core;

  localparam int GRID_MAX_COLS   = 32;
  localparam int GRID_MAX_ROWS   = 4096;
  localparam int DRAIN_CYCLES    = GRID_MAX_COLS + 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 90;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTED    = 10;

  typedef struct packed {
    logic [mnc_pkg::OUT_ROW_W-1:0] row;
    logic [mnc_pkg::OUT_COL_W-1:0] col;
    logic                          is_mine;
    mnc_pkg::count_t               count;
    logic                          last;
  } cell_report_t;

  typedef enum logic { ROW_WRITE, ROW_CELL } row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [mnc_pkg::CFG_IDX_W-1:0]  idx;
    logic [mnc_pkg::CFG_DATA_W-1:0] data;
    logic                           mine;
    logic                           typed;
    cell_report_t                   want;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_HALF, STALL_RARE, STALL_PERIODIC
  } stall_mode_t;

  localparam cell_report_t NO_REPORT = '0;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_cell_is_mine = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [mnc_pkg::OUT_ROW_W-1:0]  out_row;
  logic [mnc_pkg::OUT_COL_W-1:0]  out_col;
  logic                           out_is_mine;
  mnc_pkg::count_t                out_mine_count;
  logic                           out_last_of_run;
  logic                           cfg_we = 1'b0;
  logic [mnc_pkg::CFG_IDX_W-1:0]  cfg_index = mnc_pkg::REG_COLS_IN_USE;
  logic [mnc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [mnc_pkg::CFG_COLS_W-1:0] grid_cfg_cols = mnc_pkg::COLS_RESET;
  logic [mnc_pkg::CFG_ROWS_W-1:0] grid_cfg_rows = mnc_pkg::ROWS_RESET;
  logic [GRID_MAX_COLS-1:0]       grid_two_above = '0;
  logic [GRID_MAX_COLS-1:0]       grid_above = '0;
  logic [GRID_MAX_COLS-1:0]       grid_current = '0;
  int                             grid_row = 0;
  int                             grid_col = 0;

  cell_report_t step_reports[$];
  cell_report_t reports_due[$];

  int          mismatches = 0;
  int          cycle_count = 0;
  int          random_items = 0;
  int          burst_left = 0;
  logic        hold_off_req = 1'b0;
  logic        hold_off_done = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  stim_row_t directed_stim [35] = '{
    '{ROW_WRITE, mnc_pkg::REG_COLS_IN_USE, 13'd1,    1'b0, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_ROWS_IN_USE, 13'd1,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b1,
      '{12'd0, 5'd0, 1'b1, 4'd0, 1'b1}},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b1,
      '{12'd0, 5'd0, 1'b0, 4'd0, 1'b1}},
    '{ROW_WRITE, mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b1,
      '{12'd0, 5'd0, 1'b1, 4'd0, 1'b1}},
    '{ROW_WRITE, mnc_pkg::REG_ROWS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b1,
      '{12'd0, 5'd0, 1'b0, 4'd0, 1'b1}},
    '{ROW_WRITE, mnc_pkg::REG_COLS_IN_USE, 13'd3,    1'b0, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_ROWS_IN_USE, 13'd3,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_COLS_IN_USE, 13'd2,    1'b0, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_ROWS_IN_USE, 13'd8191, 1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_ROWS_IN_USE, 13'd2,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_COLS_IN_USE, 13'd5,    1'b0, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_ROWS_IN_USE, 13'd1,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_WRITE, mnc_pkg::REG_COLS_IN_USE, 13'd2,    1'b0, 1'b0, NO_REPORT},
    '{ROW_CELL,  mnc_pkg::REG_COLS_IN_USE, 13'd0,    1'b0, 1'b0, NO_REPORT}
  };

  mine_neighbor_count_3x3_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_is_mine (in_cell_is_mine),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_is_mine     (out_is_mine),
    .out_mine_count  (out_mine_count),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic grid_bit(logic [GRID_MAX_COLS-1:0] v, int col, int cols);
    if (col < 0 || col >= cols) return 1'b0;
    return v[col];
  endfunction

  function automatic void add_report(int row, int col, int cols,
                                     logic [GRID_MAX_COLS-1:0] up,
                                     logic [GRID_MAX_COLS-1:0] mid,
                                     logic [GRID_MAX_COLS-1:0] down);
    cell_report_t rep;
    rep.row     = mnc_pkg::OUT_ROW_W'(row);
    rep.col     = mnc_pkg::OUT_COL_W'(col);
    rep.is_mine = grid_bit(mid, col, cols);
    rep.count   = '0;
    rep.last    = 1'b0;
    if (!rep.is_mine) begin
      for (int d = -1; d <= 1; d++) begin
        rep.count = rep.count + mnc_pkg::count_t'(grid_bit(up, col + d, cols))
                              + mnc_pkg::count_t'(grid_bit(down, col + d, cols));
      end
      rep.count = rep.count + mnc_pkg::count_t'(grid_bit(mid, col - 1, cols))
                            + mnc_pkg::count_t'(grid_bit(mid, col + 1, cols));
    end
    step_reports.insert(step_reports.size(), rep);
  endfunction

  // Out-of-range register values and a position left beyond a shrunk grid
  // both saturate to the last valid column or row.
  function automatic void grid_accept_cell(logic mine);
    int           cols;
    int           rows;
    int           c;
    int           r;
    cell_report_t rep;
    cols = int'(grid_cfg_cols);
    rows = int'(grid_cfg_rows);
    if (cols < 1) cols = 1;
    if (cols > GRID_MAX_COLS) cols = GRID_MAX_COLS;
    if (rows < 1) rows = 1;
    if (rows > GRID_MAX_ROWS) rows = GRID_MAX_ROWS;
    step_reports.delete();
    c = (grid_col < cols) ? grid_col : cols - 1;
    r = (grid_row < rows) ? grid_row : rows - 1;
    if (mine) grid_current[c] = 1'b1;
    if (r >= 1) begin
      if (c >= 1) add_report(r - 1, c - 1, cols, grid_two_above, grid_above, grid_current);
      if (c == cols - 1) add_report(r - 1, c, cols, grid_two_above, grid_above, grid_current);
    end
    if (c == cols - 1) begin
      if (r == rows - 1) begin
        for (int k = 0; k < cols; k++) add_report(r, k, cols, grid_above, grid_current, '0);
        grid_two_above = '0;
        grid_above = '0;
        grid_current = '0;
        grid_row = 0;
      end else begin
        grid_two_above = grid_above;
        grid_above = grid_current;
        grid_current = '0;
        grid_row = r + 1;
      end
      grid_col = 0;
    end else begin
      grid_row = r;
      grid_col = c + 1;
    end
    if (step_reports.size() > 0) begin
      rep = step_reports.pop_back();
      rep.last = 1'b1;
      step_reports.insert(step_reports.size(), rep);
    end
  endfunction

  task automatic push_cell(input logic mine, input logic typed, input cell_report_t want);
    in_valid <= 1'b1;
    in_cell_is_mine <= mine;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    grid_accept_cell(mine);
    if (typed) begin
      reports_due.insert(reports_due.size(), want);
    end else begin
      foreach (step_reports[i]) reports_due.insert(reports_due.size(), step_reports[i]);
    end
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic wait_results_out();
    in_valid <= 1'b0;
    @(negedge clk);
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  // A word that completes no cell can still be in flight when the queue empties.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mnc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mnc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == mnc_pkg::REG_COLS_IN_USE) grid_cfg_cols = val[mnc_pkg::CFG_COLS_W-1:0];
    else if (idx == mnc_pkg::REG_ROWS_IN_USE) grid_cfg_rows = val[mnc_pkg::CFG_ROWS_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int cols_val, input int rows_val, input int n_items,
                           input int mine_pct, input int hold_at, input int pause_at);
    quiesce();
    write_reg(mnc_pkg::REG_COLS_IN_USE, mnc_pkg::CFG_DATA_W'(cols_val));
    write_reg(mnc_pkg::REG_ROWS_IN_USE, mnc_pkg::CFG_DATA_W'(rows_val));
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_off_req <= 1'b1;
      push_cell($urandom_range(0, 99) < mine_pct, 1'b0, NO_REPORT);
      random_items++;
      if (i == pause_at) wait_results_out();
      else sender_gap();
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mine_neighbor_count_3x3_core verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
        STALL_RARE: out_stall <= ($urandom_range(0, 7) == 0);
        default:    out_stall <= ((cycle_count % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    cell_report_t got;
    cell_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_row, out_col, out_is_mine, out_mine_count, out_last_of_run};
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("unexpected word: row %0d col %0d mine %0b count %0d last %0b",
                   got.row, got.col, got.is_mine, got.count, got.last);
      end else begin
        want = reports_due.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.is_mine !== want.is_mine ||
            got.count !== want.count || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED) begin
            $write("word mismatch: expected row %0d col %0d mine %0b count %0d last %0b,",
                   want.row, want.col, want.is_mine, want.count, want.last);
            $display(" got row %0d col %0d mine %0b count %0d last %0b",
                     got.row, got.col, got.is_mine, got.count, got.last);
          end
        end
      end
    end
  end

  initial begin
    int pick;
    int cols_val;
    int rows_val;
    int frame;
    int n_items;
    int pct;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_stim[i]) begin
      if (directed_stim[i].kind == ROW_WRITE) begin
        quiesce();
        write_reg(directed_stim[i].idx, directed_stim[i].data);
      end else begin
        push_cell(directed_stim[i].mine, directed_stim[i].typed, directed_stim[i].want);
        sender_gap();
      end
    end

    // Full-width frame: the receiver backs the block up early on, and later
    // the sender waits for every outstanding word.
    run_phase(GRID_MAX_COLS, 2, 2 * GRID_MAX_COLS, 50, 5, 45);
    run_phase(1, GRID_MAX_ROWS, 16, 50, -1, -1);

    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      cols_val = (pick == 0) ? 63 : (pick == 1) ? 0 : $urandom_range(1, 6);
      if (cols_val == 63) rows_val = 1;
      else rows_val = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
      frame = ((cols_val == 63) ? GRID_MAX_COLS : (cols_val == 0) ? 1 : cols_val) *
              ((rows_val == 0) ? 1 : rows_val);
      n_items = frame;
      if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, frame);
      pick = $urandom_range(0, 5);
      pct = (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(10, 90);
      run_phase(cols_val, rows_val, n_items, pct, -1, -1);
    end

    quiesce();
    if (mismatches == 0) begin
      $display("mine_neighbor_count_3x3_core verification clean");
    end else begin
      $display("mine_neighbor_count_3x3_core verification failed");
    end
    $finish;
  end

endmodule
